/* hdl/nsy_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nelson-Siegel yield package
// Shared constants, register codes and the item that passes from front to back.
// ----------------------------------------------------------------------------
package nsy_pkg;

	localparam int NSY_TIME_BITS  = 24;
	localparam int NSY_COEFF_BITS = 32;
	localparam int NSY_CFG_BITS   = 32;
	localparam int CFG_INDEX_BITS = 3;

	localparam int RATE_BITS      = 20;
	localparam int LIMIT_BITS     = 20;
	localparam int X_BITS         = 32;
	localparam int FRAC_SHIFT     = 12;
	localparam int K_BITS         = 13;
	localparam int E_BITS         = 33;
	localparam int K_ZERO         = 33;
	localparam int TAYLOR_TERMS   = 12;
	localparam int NUM_BITS       = 51;
	localparam int SER_BITS       = 32;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [31:0] LN2_Q32    = 32'd2977044472;
	localparam logic [12:0] K_RECIP    = 13'd5909;
	localparam logic [31:0] DIV3_RECIP = 32'd1431655766;

	localparam logic [RATE_BITS-1:0]  RESET_DECAY = 20'h10000;
	localparam logic [LIMIT_BITS-1:0] RESET_LIMIT = 20'd1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LEVEL        = 3'd0,
		REG_SLOPE        = 3'd1,
		REG_CURVE        = 3'd2,
		REG_DECAY        = 3'd3,
		REG_START        = 3'd4,
		REG_FIRST_LIMIT  = 3'd5,
		REG_SECOND_LIMIT = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [X_BITS-1:0]   x;
		logic                err;
		logic                first_ser;
		logic                second_ser;
		logic [SER_BITS-1:0] s1_ser;
		logic [SER_BITS-1:0] s2_ser;
	} nsy_item_t;

endpackage

/* hdl/nsy_query_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query channel
// Carries one maturity time per transaction.
// ----------------------------------------------------------------------------
interface nsy_query_if import nsy_pkg::*; #(parameter int TIME_BITS = NSY_TIME_BITS);
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] query_time;
	modport source (output valid, output query_time, input ready);
	modport sink (input valid, input query_time, output ready);
endinterface

/* hdl/nsy_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Carries one yield and its error flag per transaction.
// ----------------------------------------------------------------------------
interface nsy_result_if import nsy_pkg::*; #(parameter int COEFF_BITS = NSY_COEFF_BITS);
	logic                  valid;
	logic                  ready;
	logic [COEFF_BITS-1:0] yield_value;
	logic                  time_error;
	modport source (output valid, output yield_value, output time_error, input ready);
	modport sink (input valid, input yield_value, input time_error, output ready);
endinterface

/* hdl/nsy_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data per transaction.
// ----------------------------------------------------------------------------
interface nsy_cfg_if import nsy_pkg::*; #(parameter int DATA_BITS = NSY_CFG_BITS);
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [DATA_BITS-1:0]      data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/nsy_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nelson-Siegel front end
// Takes queries, forms the scaled time x, picks series or exact per shape and
// evaluates both series forms.
// ----------------------------------------------------------------------------
module nsy_front import nsy_pkg::*; #(
	parameter int TIME_BITS = NSY_TIME_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	nsy_query_if.sink             query,
	input  logic [RATE_BITS-1:0]  decay_rate,
	input  logic [TIME_BITS-1:0]  start_time,
	input  logic [LIMIT_BITS-1:0] first_limit,
	input  logic [LIMIT_BITS-1:0] second_limit,
	input  logic                  queue_full,
	output logic                  push,
	output nsy_item_t             item
);

	localparam int PROD_BITS = TIME_BITS + RATE_BITS;
	localparam int XF_BITS   = (PROD_BITS - FRAC_SHIFT > X_BITS) ?
		PROD_BITS - FRAC_SHIFT : X_BITS + 1;
	localparam int SQ_BITS   = 2 * LIMIT_BITS;
	localparam int X2_BITS   = SQ_BITS - 10;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic err_s1, err_s2, err_s3, err_s4, err_s5;
	logic [TIME_BITS-1:0] d_s1;
	logic [PROD_BITS-1:0] prod_s2;
	logic [X_BITS-1:0] x_s3, x_s4, x_s5;
	logic first_s4, second_s4, first_s5, second_s5;
	logic [X2_BITS-1:0] x2_s4, q3_s5;
	logic [XF_BITS-1:0] x_full;
	logic [X_BITS-1:0] x_sat;
	logic [SQ_BITS-1:0] sq;
	logic [X2_BITS+31:0] q3_prod;

	assign adv         = !v_s5 || !queue_full;
	assign query.ready = adv;
	assign push        = v_s5 && !queue_full;

	assign x_full  = XF_BITS'(prod_s2 >> FRAC_SHIFT);
	assign x_sat   = (|x_full[XF_BITS-1:X_BITS]) ? '1 : x_full[X_BITS-1:0];
	assign sq      = SQ_BITS'(x_s3[LIMIT_BITS-1:0]) * SQ_BITS'(x_s3[LIMIT_BITS-1:0]);
	assign q3_prod = (X2_BITS+32)'(x2_s4) * (X2_BITS+32)'(DIV3_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s1    <= query.query_time < start_time;
			d_s1      <= query.query_time - start_time;
			err_s2    <= err_s1;
			prod_s2   <= PROD_BITS'(decay_rate) * PROD_BITS'(d_s1);
			err_s3    <= err_s2;
			x_s3      <= x_sat;
			err_s4    <= err_s3;
			x_s4      <= x_s3;
			first_s4  <= x_s3 <= X_BITS'(first_limit);
			second_s4 <= x_s3 <= X_BITS'(second_limit);
			x2_s4     <= sq[SQ_BITS-1:10];
			err_s5    <= err_s4;
			x_s5      <= x_s4;
			first_s5  <= first_s4;
			second_s5 <= second_s4;
			q3_s5     <= q3_prod[X2_BITS+31:32];
		end
	end

	always_comb begin
		item.x          = x_s5;
		item.err        = err_s5;
		item.first_ser  = first_s5;
		item.second_ser = second_s5;
		item.s1_ser     = 32'h4000_0000 - {3'b0, x_s5[LIMIT_BITS-1:0], 9'b0}
			+ SER_BITS'(q3_s5 >> 1);
		item.s2_ser     = {3'b0, x_s5[LIMIT_BITS-1:0], 9'b0} - SER_BITS'(q3_s5);
	end

endmodule

/* hdl/nsy_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nelson-Siegel item queue
// Short FIFO that lets the front end and back end stall independently.
// ----------------------------------------------------------------------------
module nsy_queue import nsy_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  nsy_item_t item_in,
	input  logic      pop,
	output nsy_item_t head,
	output logic      full,
	output logic      empty
);

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	nsy_item_t mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_q, rd_q;
	logic [CNT_BITS-1:0] cnt_q;

	assign full  = cnt_q == CNT_BITS'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("Queue written while full.");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("Queue read while empty.");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(QUEUE_DEPTH))
		else $error("Queue count out of range.");

endmodule

/* hdl/nsy_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nelson-Siegel back end
// Pipelined exp(-x), pipelined restoring divider for the exact shape, and the
// weighted sum with saturation into the output register.
// ----------------------------------------------------------------------------
module nsy_back import nsy_pkg::*; #(
	parameter int COEFF_BITS = NSY_COEFF_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nsy_item_t                    head,
	input  logic                         queue_empty,
	output logic                         pop,
	input  logic signed [COEFF_BITS-1:0] level_coeff,
	input  logic signed [COEFF_BITS-1:0] slope_coeff,
	input  logic signed [COEFF_BITS-1:0] curve_coeff,
	nsy_result_if.source                 result
);

	localparam int TSTAGES   = 2 * (TAYLOR_TERMS - 1);
	localparam int S_BITS    = NUM_BITS + 2;
	localparam int SPLIT     = 27;
	localparam int Q30       = 30;
	localparam int FULL_BITS = COEFF_BITS + S_BITS + 1;
	localparam int P_BITS    = FULL_BITS - Q30;
	localparam int Y_BITS    = P_BITS + 3;
	localparam int HI_BITS   = COEFF_BITS + S_BITS - SPLIT;
	localparam int LO_BITS   = COEFF_BITS + SPLIT;

	logic adv;

	// Range reduction
	logic b0_v, b1_v;
	nsy_item_t b0_it, b1_it;
	logic [K_BITS-1:0] b0_k, b1_k;
	logic [E_BITS-1:0] b1_r;
	logic [44:0] kmul, kprod, r0;
	logic r_ge;

	// Taylor sum, stage 0 holds the reduced argument
	logic              t_v   [0:TSTAGES];
	nsy_item_t         t_it  [0:TSTAGES];
	logic [K_BITS-1:0] t_k   [0:TSTAGES];
	logic [31:0]       t_r   [0:TSTAGES];
	logic [31:0]       t_val [0:TSTAGES];
	logic [E_BITS-1:0] t_sum [0:TSTAGES];

	// Divider, stage 0 holds exp(-x) and the numerator
	logic                d_v   [0:NUM_BITS];
	nsy_item_t           d_it  [0:NUM_BITS];
	logic [E_BITS-1:0]   d_e   [0:NUM_BITS];
	logic [31:0]         d_rem [0:NUM_BITS];
	logic [NUM_BITS-1:0] d_nq  [0:NUM_BITS];
	logic [E_BITS-1:0]   e_next;

	// Combine
	logic c0_v, c1_v, out_v_q;
	logic c0_err, c1_err, out_err_q;
	logic c0_neg1, c0_neg2, c1_neg1, c1_neg2;
	logic [COEFF_BITS-1:0] c0_mc1, c0_mc2;
	logic [S_BITS-1:0] c0_ms1, c0_ms2;
	logic [HI_BITS-1:0] c1_ph1, c1_ph2;
	logic [LO_BITS-1:0] c1_pl1, c1_pl2;
	logic [COEFF_BITS-1:0] out_y_q;
	logic [S_BITS-1:0] s1_w, s2_w, ms1, ms2;
	logic [COEFF_BITS-1:0] mc1, mc2;
	logic [FULL_BITS-1:0] full1, full2;
	logic [P_BITS-1:0] p1, p2;
	logic signed [Y_BITS-1:0] v1, v2, y_sum;
	logic [COEFF_BITS-1:0] y_sat;

	assign adv = !out_v_q || result.ready;
	assign pop = adv && !queue_empty;

	assign kmul  = 45'(head.x) * 45'(K_RECIP);
	assign kprod = 45'(b0_k) * 45'(LN2_Q32);
	assign r0    = {1'b0, b0_it.x, 12'b0} - kprod;
	assign r_ge  = b1_r >= {1'b0, LN2_Q32};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_v   <= 1'b0;
			b1_v   <= 1'b0;
			t_v[0] <= 1'b0;
		end else if (adv) begin
			b0_v   <= !queue_empty;
			b1_v   <= b0_v;
			t_v[0] <= b1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b0_it    <= head;
			b0_k     <= kmul[44:32];
			b1_it    <= b0_it;
			b1_k     <= b0_k;
			b1_r     <= r0[E_BITS-1:0];
			t_it[0]  <= b1_it;
			t_k[0]   <= b1_k + K_BITS'(r_ge);
			t_r[0]   <= r_ge ? 32'(b1_r - {1'b0, LN2_Q32}) : b1_r[31:0];
			t_val[0] <= r_ge ? 32'(b1_r - {1'b0, LN2_Q32}) : b1_r[31:0];
			t_sum[0] <= 33'h1_0000_0000
				- (r_ge ? E_BITS'(b1_r - {1'b0, LN2_Q32}) : b1_r);
		end
	end

	for (genvar s = 1; s <= TSTAGES; s++) begin : g_taylor
		logic [31:0]       val_next;
		logic [E_BITS-1:0] sum_next;

		if (s % 2 == 1) begin : g_mul
			logic [63:0] prod;
			assign prod     = 64'(t_val[s-1]) * 64'(t_r[s-1]);
			assign val_next = prod[63:32];
			assign sum_next = t_sum[s-1];
		end else begin : g_div
			localparam int N = s / 2 + 1;
			localparam int L = $clog2(N);
			localparam logic [64:0] RECIP =
				((65'd1 << (32 + L)) + 65'(N) - 65'd1) / 65'(N);
			logic [64:0] prod;
			assign prod     = 65'(t_val[s-1]) * RECIP;
			assign val_next = 32'(prod >> (32 + L));
			if (N % 2 == 0) begin : g_add
				assign sum_next = t_sum[s-1] + E_BITS'(val_next);
			end else begin : g_sub
				assign sum_next = t_sum[s-1] - E_BITS'(val_next);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				t_v[s] <= 1'b0;
			end else if (adv) begin
				t_v[s] <= t_v[s-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				t_it[s]  <= t_it[s-1];
				t_k[s]   <= t_k[s-1];
				t_r[s]   <= t_r[s-1];
				t_val[s] <= val_next;
				t_sum[s] <= sum_next;
			end
		end
	end

	assign e_next = (t_k[TSTAGES] >= K_BITS'(K_ZERO)) ? '0 :
		t_sum[TSTAGES] >> t_k[TSTAGES][5:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_v[0] <= 1'b0;
		end else if (adv) begin
			d_v[0] <= t_v[TSTAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_it[0]  <= t_it[TSTAGES];
			d_e[0]   <= e_next;
			d_rem[0] <= '0;
			d_nq[0]  <= {33'h1_0000_0000 - e_next, 18'b0};
		end
	end

	for (genvar i = 1; i <= NUM_BITS; i++) begin : g_divide
		logic [32:0] remw, xe;
		logic        ge;

		assign remw = {d_rem[i-1], d_nq[i-1][NUM_BITS-1]};
		assign xe   = {1'b0, d_it[i-1].x};
		assign ge   = remw >= xe;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d_v[i] <= 1'b0;
			end else if (adv) begin
				d_v[i] <= d_v[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				d_it[i]  <= d_it[i-1];
				d_e[i]   <= d_e[i-1];
				d_rem[i] <= ge ? 32'(remw - xe) : remw[31:0];
				d_nq[i]  <= {d_nq[i-1][NUM_BITS-2:0], ge};
			end
		end
	end

	always_comb begin
		s1_w = d_it[NUM_BITS].first_ser ? S_BITS'(d_it[NUM_BITS].s1_ser) :
			S_BITS'(d_nq[NUM_BITS]);
		s2_w = d_it[NUM_BITS].second_ser ? S_BITS'(d_it[NUM_BITS].s2_ser) :
			S_BITS'(d_nq[NUM_BITS]) - S_BITS'(d_e[NUM_BITS] >> 2);
		ms1  = s1_w[S_BITS-1] ? -s1_w : s1_w;
		ms2  = s2_w[S_BITS-1] ? -s2_w : s2_w;
		mc1  = slope_coeff[COEFF_BITS-1] ? -slope_coeff : slope_coeff;
		mc2  = curve_coeff[COEFF_BITS-1] ? -curve_coeff : curve_coeff;
	end

	always_comb begin
		full1 = (FULL_BITS'(c1_ph1) << SPLIT) + FULL_BITS'(c1_pl1);
		full2 = (FULL_BITS'(c1_ph2) << SPLIT) + FULL_BITS'(c1_pl2);
		p1    = P_BITS'(full1 >> Q30);
		p2    = P_BITS'(full2 >> Q30);
		v1    = c1_neg1 ? -$signed(Y_BITS'(p1)) : $signed(Y_BITS'(p1));
		v2    = c1_neg2 ? -$signed(Y_BITS'(p2)) : $signed(Y_BITS'(p2));
		y_sum = Y_BITS'(level_coeff) + v1 + v2;
		if ((&y_sum[Y_BITS-1:COEFF_BITS-1]) || !(|y_sum[Y_BITS-1:COEFF_BITS-1])) begin
			y_sat = y_sum[COEFF_BITS-1:0];
		end else if (y_sum[Y_BITS-1]) begin
			y_sat = {1'b1, {(COEFF_BITS-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(COEFF_BITS-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c0_v    <= 1'b0;
			c1_v    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			c0_v    <= d_v[NUM_BITS];
			c1_v    <= c0_v;
			out_v_q <= c1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c0_err    <= d_it[NUM_BITS].err;
			c0_neg1   <= slope_coeff[COEFF_BITS-1] ^ s1_w[S_BITS-1];
			c0_neg2   <= curve_coeff[COEFF_BITS-1] ^ s2_w[S_BITS-1];
			c0_mc1    <= mc1;
			c0_mc2    <= mc2;
			c0_ms1    <= ms1;
			c0_ms2    <= ms2;
			c1_err    <= c0_err;
			c1_neg1   <= c0_neg1;
			c1_neg2   <= c0_neg2;
			c1_ph1    <= HI_BITS'(c0_mc1) * HI_BITS'(c0_ms1[S_BITS-1:SPLIT]);
			c1_pl1    <= LO_BITS'(c0_mc1) * LO_BITS'(c0_ms1[SPLIT-1:0]);
			c1_ph2    <= HI_BITS'(c0_mc2) * HI_BITS'(c0_ms2[S_BITS-1:SPLIT]);
			c1_pl2    <= LO_BITS'(c0_mc2) * LO_BITS'(c0_ms2[SPLIT-1:0]);
			out_err_q <= c1_err;
			out_y_q   <= c1_err ? '0 : y_sat;
		end
	end

	assign result.valid       = out_v_q;
	assign result.yield_value = out_y_q;
	assign result.time_error  = out_err_q;

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.time_error |-> result.yield_value == '0)
		else $error("Early query produced a nonzero yield.");

endmodule

/* hdl/nelson_siegel_yield_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nelson-Siegel yield core
// Evaluates c0 + c1*s1(x) + c2*s2(x) with x = lambda*(t - t0) for each query.
//
//   Channel   Direction   Transaction
//   query     in          one maturity time t
//   result    out         one saturated yield and the early-time flag
//   cfg       in          one register write, index and data
//
// One query per cycle is sustained while results are taken. The path runs
// through 5 front stages, the queue, 3 range-reduction stages, 22 Taylor
// stages, one exp stage, 51 divider stages and 3 combine stages. A stalled
// result holds the whole back end; the front end keeps taking queries until
// the four-entry queue fills. After reset the registers hold their documented
// defaults and no clearing pass is needed.
// ----------------------------------------------------------------------------
module nelson_siegel_yield_core import nsy_pkg::*; #(
	parameter int TIME_BITS  = NSY_TIME_BITS,
	parameter int COEFF_BITS = NSY_COEFF_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	nsy_query_if.sink    query,
	nsy_result_if.source result,
	nsy_cfg_if.sink      cfg
);

	logic signed [COEFF_BITS-1:0] level_q, slope_q, curve_q;
	logic [RATE_BITS-1:0]  decay_q;
	logic [TIME_BITS-1:0]  start_q;
	logic [LIMIT_BITS-1:0] first_limit_q, second_limit_q;

	logic      push, pop, queue_full, queue_empty;
	nsy_item_t item, head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q        <= '0;
			slope_q        <= '0;
			curve_q        <= '0;
			decay_q        <= RESET_DECAY;
			start_q        <= '0;
			first_limit_q  <= RESET_LIMIT;
			second_limit_q <= RESET_LIMIT;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_LEVEL:        level_q        <= COEFF_BITS'(cfg.data);
				REG_SLOPE:        slope_q        <= COEFF_BITS'(cfg.data);
				REG_CURVE:        curve_q        <= COEFF_BITS'(cfg.data);
				REG_DECAY:        decay_q        <= RATE_BITS'(cfg.data);
				REG_START:        start_q        <= TIME_BITS'(cfg.data);
				REG_FIRST_LIMIT:  first_limit_q  <= LIMIT_BITS'(cfg.data);
				REG_SECOND_LIMIT: second_limit_q <= LIMIT_BITS'(cfg.data);
				default: begin
				end
			endcase
		end
	end

	nsy_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.query       (query),
		.decay_rate  (decay_q),
		.start_time  (start_q),
		.first_limit (first_limit_q),
		.second_limit(second_limit_q),
		.queue_full  (queue_full),
		.push        (push),
		.item        (item)
	);

	nsy_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item_in(item),
		.pop    (pop),
		.head   (head),
		.full   (queue_full),
		.empty  (queue_empty)
	);

	nsy_back #(.COEFF_BITS(COEFF_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.queue_empty(queue_empty),
		.pop        (pop),
		.level_coeff(level_q),
		.slope_coeff(slope_q),
		.curve_coeff(curve_q),
		.result     (result)
	);

endmodule
